/* rtl/tdpt_pkg.sv */
// tdpt_pkg: shared constants, register map and digit pattern table
// for the timed digit pattern time display; no dependencies
package tdpt_pkg;

	localparam int PIN_COUNT = 5;
	localparam int CNT_W     = 16;
	localparam int VAL_W     = 7;
	localparam int DIGIT_W   = 4;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_DIGIT     = 2'd0;
	localparam logic [1:0] REG_DIGIT_GAP = 2'd1;
	localparam logic [1:0] REG_UNIT_GAP  = 2'd2;

	localparam logic [CNT_W-1:0] DIGIT_TICKS_RST     = 16'd500;
	localparam logic [CNT_W-1:0] DIGIT_GAP_TICKS_RST = 16'd300;
	localparam logic [CNT_W-1:0] UNIT_GAP_TICKS_RST  = 16'd800;

	// divide by ten as multiply by 205 and shift by 11, exact for 7-bit values
	localparam int DIV10_MUL   = 205;
	localparam int DIV10_SHIFT = 11;
	localparam int TEN         = 10;

	localparam logic [PIN_COUNT-1:0] ERROR_PATTERN = '1;

	function automatic logic [PIN_COUNT-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
		logic [PIN_COUNT-1:0] p;
		unique case (d)
			4'd0: p = 5'h01;
			4'd1: p = 5'h02;
			4'd2: p = 5'h04;
			4'd3: p = 5'h08;
			4'd4: p = 5'h10;
			4'd5: p = 5'h05;
			4'd6: p = 5'h0A;
			4'd7: p = 5'h14;
			4'd8: p = 5'h11;
			4'd9: p = 5'h15;
			default: p = ERROR_PATTERN;
		endcase
		return p;
	endfunction

endpackage

/* rtl/timed_digit_pattern_time_display.sv */
// timed_digit_pattern_time_display: start/tick sequencer that shows hours and
// minutes digit by digit as pin patterns; depends on tdpt_pkg
//
// path: an accepted word passes the input register, then the result register,
// to its result word; throughput: one word per cycle unless the result stalls,
// set by the single pass of phase and tick counter update between the two registers
// reset: asynchronous, active low; clears phase, tick counter, digits and the
// config registers to their defaults (500, 300, 800 ticks)
module timed_digit_pattern_time_display import tdpt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  logic [VAL_W-1:0]     hours,
	input  logic [VAL_W-1:0]     minutes,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIN_COUNT-1:0] pins,
	output logic                 busy_res,
	output logic                 done_res,
	// config port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	// phase codes, in display order
	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_HT   = 3'd1;
	localparam logic [2:0] PH_GAP1 = 3'd2;
	localparam logic [2:0] PH_HO   = 3'd3;
	localparam logic [2:0] PH_UGAP = 3'd4;
	localparam logic [2:0] PH_MT   = 3'd5;
	localparam logic [2:0] PH_GAP2 = 3'd6;
	localparam logic [2:0] PH_MO   = 3'd7;

	// config registers
	logic [CNT_W-1:0] digit_ticks_q, digit_gap_ticks_q, unit_gap_ticks_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_ticks_q     <= DIGIT_TICKS_RST;
			digit_gap_ticks_q <= DIGIT_GAP_TICKS_RST;
			unit_gap_ticks_q  <= UNIT_GAP_TICKS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_DIGIT:     digit_ticks_q     <= pwdata[CNT_W-1:0];
				REG_DIGIT_GAP: digit_gap_ticks_q <= pwdata[CNT_W-1:0];
				REG_UNIT_GAP:  unit_gap_ticks_q  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DIGIT:     prdata = {{(DATA_W-CNT_W){1'b0}}, digit_ticks_q};
			REG_DIGIT_GAP: prdata = {{(DATA_W-CNT_W){1'b0}}, digit_gap_ticks_q};
			REG_UNIT_GAP:  prdata = {{(DATA_W-CNT_W){1'b0}}, unit_gap_ticks_q};
			default:       prdata = '0;
		endcase
	end

	// input register: one word waits here while a result is stalled
	logic             valid_s1;
	logic             op_s1;
	logic [VAL_W-1:0] hours_s1, minutes_s1;
	logic             advance;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= operation;
			hours_s1   <= hours;
			minutes_s1 <= minutes;
		end
	end

	// sequencer state
	logic [2:0]         phase_q;
	logic [CNT_W-1:0]   tick_count_q;
	logic [DIGIT_W-1:0] digit_q [4];

	// split by ten through the reciprocal
	logic [VAL_W+7:0]   h_prod, m_prod;
	logic [DIGIT_W-1:0] h_tens, h_ones, m_tens, m_ones;
	logic [VAL_W-1:0]   h_rem, m_rem;

	always_comb begin
		h_prod = (VAL_W+8)'(hours_s1) * (VAL_W+8)'(DIV10_MUL);
		m_prod = (VAL_W+8)'(minutes_s1) * (VAL_W+8)'(DIV10_MUL);
		h_tens = h_prod[DIV10_SHIFT +: DIGIT_W];
		m_tens = m_prod[DIV10_SHIFT +: DIGIT_W];
		h_rem  = hours_s1 - VAL_W'(h_tens) * VAL_W'(TEN);
		m_rem  = minutes_s1 - VAL_W'(m_tens) * VAL_W'(TEN);
		h_ones = h_rem[DIGIT_W-1:0];
		m_ones = m_rem[DIGIT_W-1:0];
	end

	// segment lengths; a zero digit duration counts as one tick
	function automatic logic [CNT_W-1:0] seg_len(input logic [2:0] ph,
			input logic [CNT_W-1:0] dig, input logic [CNT_W-1:0] dgap,
			input logic [CNT_W-1:0] ugap);
		logic [CNT_W-1:0] len;
		unique case (ph)
			PH_GAP1, PH_GAP2: len = dgap;
			PH_UGAP:          len = ugap;
			default:          len = (dig == '0) ? CNT_W'(1) : dig;
		endcase
		return len;
	endfunction

	logic [2:0]       phase_d, next_ph;
	logic [CNT_W-1:0] tick_count_d;
	logic [CNT_W:0]   cnt;
	logic             start_load, done_d;
	logic             next_is_gap;

	always_comb begin
		phase_d      = phase_q;
		tick_count_d = tick_count_q;
		done_d       = 1'b0;
		start_load   = 1'b0;
		cnt          = {1'b0, tick_count_q} + (CNT_W+1)'(1);
		// a gap of zero ticks is passed over; gaps never sit next to each other
		next_ph      = phase_q + 3'd1;
		next_is_gap  = (next_ph == PH_GAP1) || (next_ph == PH_UGAP) || (next_ph == PH_GAP2);
		if (next_is_gap && seg_len(next_ph, digit_ticks_q, digit_gap_ticks_q,
				unit_gap_ticks_q) == '0) begin
			next_ph = next_ph + 3'd1;
		end
		if (!op_s1) begin
			if (phase_q == PH_IDLE) begin
				start_load   = 1'b1;
				phase_d      = (h_tens != '0) ? PH_HT : PH_HO;
				tick_count_d = '0;
			end
		end else if (phase_q != PH_IDLE) begin
			if (cnt >= {1'b0, seg_len(phase_q, digit_ticks_q, digit_gap_ticks_q,
					unit_gap_ticks_q)}) begin
				tick_count_d = '0;
				if (phase_q == PH_MO) begin
					// last digit ran out: sequence over
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end else begin
					phase_d = next_ph;
				end
			end else begin
				tick_count_d = cnt[CNT_W-1:0];
			end
		end
	end

	logic [PIN_COUNT-1:0] pins_d;

	// pattern for the phase about to be shown; digits come fresh on a start
	always_comb begin
		logic [DIGIT_W-1:0] ht, ho, mt, mo;
		ht = start_load ? h_tens : digit_q[0];
		ho = start_load ? h_ones : digit_q[1];
		mt = start_load ? m_tens : digit_q[2];
		mo = start_load ? m_ones : digit_q[3];
		unique case (phase_d)
			PH_HT:   pins_d = digit_pattern(ht);
			PH_HO:   pins_d = digit_pattern(ho);
			PH_MT:   pins_d = digit_pattern(mt);
			PH_MO:   pins_d = digit_pattern(mo);
			default: pins_d = '0;
		endcase
	end

	logic step;
	assign step = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_count_q <= '0;
			digit_q[0]   <= '0;
			digit_q[1]   <= '0;
			digit_q[2]   <= '0;
			digit_q[3]   <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
			if (start_load) begin
				digit_q[0] <= h_tens;
				digit_q[1] <= h_ones;
				digit_q[2] <= m_tens;
				digit_q[3] <= m_ones;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pins     <= pins_d;
			busy_res <= (phase_d != PH_IDLE);
			done_res <= done_d;
		end
	end

	// the end-of-sequence word never claims to be busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done word reported busy");

	// pins stay dark whenever no sequence runs
	a_idle_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> pins == '0)
		else $error("pins lit while idle");

	// the tick counter is parked at zero while idle
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tick_count_q == '0)
		else $error("tick counter running while idle");

	// a tick never advances state past a stalled result
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(phase_q) && $stable(tick_count_q))
		else $error("state moved while result stalled");

endmodule
